[rtl/smpq_pkg.sv]
// Shared types and constants for the sorted minimum priority queue.
// No dependencies; every other file in the project uses this package.
`default_nettype none

package smpq_pkg;

    localparam int CAPACITY      = 16;
    localparam int VALUE_BITS    = 32;
    localparam int PRIORITY_BITS = 16;
    localparam int COUNT_BITS    = $clog2(CAPACITY + 1);

    typedef enum logic {
        OP_ENQUEUE = 1'b0,
        OP_DEQUEUE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_ENQUEUED = 2'd0,
        ST_DEQUEUED = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic exec;
    } cmd_t;

endpackage

`default_nettype wire

[rtl/smpq_req_if.sv]
// Request channel interface: operation, value tag and priority.
// Depends on smpq_pkg.
`default_nettype none

interface smpq_req_if;
    logic                                         valid;
    logic                                         ready;
    smpq_pkg::op_t                                op;
    logic [smpq_pkg::VALUE_BITS-1:0]              item_value;
    logic signed [smpq_pkg::PRIORITY_BITS-1:0]    item_priority;

    modport source (output valid, op, item_value, item_priority, input ready);
    modport sink   (input valid, op, item_value, item_priority, output ready);
endinterface

`default_nettype wire

[rtl/smpq_rsp_if.sv]
// Response channel interface: status and the removed entry.
// Depends on smpq_pkg.
`default_nettype none

interface smpq_rsp_if;
    logic                                         valid;
    logic                                         ready;
    smpq_pkg::status_t                            status;
    logic [smpq_pkg::VALUE_BITS-1:0]              out_value;
    logic signed [smpq_pkg::PRIORITY_BITS-1:0]    out_priority;

    modport source (output valid, status, out_value, out_priority, input ready);
    modport sink   (input valid, status, out_value, out_priority, output ready);
endinterface

`default_nettype wire

[rtl/smpq_ctrl.sv]
// Controller state machine of the priority queue: request handshake,
// operation sequencing and response valid. Depends on smpq_pkg.
`default_nettype none

module smpq_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    output smpq_pkg::cmd_t      cmd
);

    smpq_pkg::state_t state_reg, state_next;
    logic             rsp_valid_reg, rsp_valid_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg     <= smpq_pkg::S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        req_ready      = 1'b0;
        cmd.load_item  = 1'b0;
        cmd.exec       = 1'b0;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        case (state_reg)
            smpq_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = smpq_pkg::S_EXEC;
                end
            end
            smpq_pkg::S_EXEC:
            begin
                // The operation runs only when the response register is free or its response is being taken.
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.exec       = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = smpq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = smpq_pkg::S_IDLE;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;

    a_exec_gives_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> rsp_valid_reg)
        else $error("executed operation did not raise response valid");

    a_accept_goes_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (state_reg == smpq_pkg::S_EXEC))
        else $error("accepted request did not start execution");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == smpq_pkg::S_EXEC && rsp_valid_reg && !rsp_ready)
        |=> (state_reg == smpq_pkg::S_EXEC && rsp_valid_reg))
        else $error("operation overwrote a response that was not taken");

endmodule

`default_nettype wire

[rtl/smpq_datapath.sv]
// Datapath of the priority queue: sorted entry store with parallel compare
// and shift, item register and response payload register. Depends on smpq_pkg.
`default_nettype none

module smpq_datapath (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire smpq_pkg::cmd_t                           cmd,
    input  wire smpq_pkg::op_t                            op,
    input  wire logic [smpq_pkg::VALUE_BITS-1:0]          item_value,
    input  wire logic signed [smpq_pkg::PRIORITY_BITS-1:0] item_priority,
    output smpq_pkg::status_t                             status,
    output logic [smpq_pkg::VALUE_BITS-1:0]               out_value,
    output logic signed [smpq_pkg::PRIORITY_BITS-1:0]     out_priority
);

    localparam int N  = smpq_pkg::CAPACITY;
    localparam int VB = smpq_pkg::VALUE_BITS;
    localparam int PB = smpq_pkg::PRIORITY_BITS;
    localparam int CB = smpq_pkg::COUNT_BITS;

    logic [VB-1:0]        val_reg  [N];
    logic [VB-1:0]        val_next [N];
    logic signed [PB-1:0] pri_reg  [N];
    logic signed [PB-1:0] pri_next [N];
    logic [CB-1:0]        count_reg, count_next;

    smpq_pkg::op_t        op_reg;
    logic [VB-1:0]        item_val_reg;
    logic signed [PB-1:0] item_pri_reg;

    smpq_pkg::status_t    status_reg, status_next;
    logic [VB-1:0]        rsp_val_reg, rsp_val_next;
    logic signed [PB-1:0] rsp_pri_reg, rsp_pri_next;

    logic [N-1:0]         stay;
    logic                 is_full, is_empty;

    assign is_full  = (count_reg == CB'(N));
    assign is_empty = (count_reg == '0);

    // Entries that stay in front of the new one: valid and not greater.
    // The store is sorted, so this vector is a run of ones from index 0.
    always_comb begin
        for (int i = 0; i < N; i++)
        begin
            stay[i] = (CB'(i) < count_reg) && (pri_reg[i] <= item_pri_reg);
        end
    end

    always_comb begin
        for (int i = 0; i < N; i++)
        begin
            val_next[i] = val_reg[i];
            pri_next[i] = pri_reg[i];
        end
        count_next   = count_reg;
        status_next  = status_reg;
        rsp_val_next = rsp_val_reg;
        rsp_pri_next = rsp_pri_reg;

        if (cmd.exec)
        begin
            rsp_val_next = '0;
            rsp_pri_next = '0;
            if (op_reg == smpq_pkg::OP_ENQUEUE)
            begin
                if (is_full)
                begin
                    status_next = smpq_pkg::ST_FULL;
                end
                else
                begin
                    status_next = smpq_pkg::ST_ENQUEUED;
                    count_next  = count_reg + 1'b1;
                    if (!stay[0])
                    begin
                        val_next[0] = item_val_reg;
                        pri_next[0] = item_pri_reg;
                    end
                    for (int i = 1; i < N; i++)
                    begin
                        if (!stay[i])
                        begin
                            if (stay[i-1])
                            begin
                                val_next[i] = item_val_reg;
                                pri_next[i] = item_pri_reg;
                            end
                            else
                            begin
                                val_next[i] = val_reg[i-1];
                                pri_next[i] = pri_reg[i-1];
                            end
                        end
                    end
                end
            end
            else
            begin
                if (is_empty)
                begin
                    status_next = smpq_pkg::ST_EMPTY;
                end
                else
                begin
                    status_next  = smpq_pkg::ST_DEQUEUED;
                    rsp_val_next = val_reg[0];
                    rsp_pri_next = pri_reg[0];
                    count_next   = count_reg - 1'b1;
                    for (int i = 0; i < N - 1; i++)
                    begin
                        val_next[i] = val_reg[i+1];
                        pri_next[i] = pri_reg[i+1];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk) begin
        for (int i = 0; i < N; i++)
        begin
            val_reg[i] <= val_next[i];
            pri_reg[i] <= pri_next[i];
        end
        status_reg  <= status_next;
        rsp_val_reg <= rsp_val_next;
        rsp_pri_reg <= rsp_pri_next;
        if (cmd.load_item)
        begin
            op_reg       <= op;
            item_val_reg <= item_value;
            item_pri_reg <= item_priority;
        end
    end

    assign status       = status_reg;
    assign out_value    = rsp_val_reg;
    assign out_priority = rsp_pri_reg;

endmodule

`default_nettype wire

[rtl/sorted_min_priority_queue.sv]
// Top level of the sorted minimum priority queue: controller plus datapath.
// Depends on smpq_pkg, smpq_req_if, smpq_rsp_if, smpq_ctrl, smpq_datapath.
//
// Usage:
// The req channel carries one transaction per operation. With op set to
// enqueue, item_value is stored with the signed item_priority; with op set
// to dequeue, the stored entry with the smallest priority is removed.
// Entries of equal priority leave in the order they arrived.
// The rsp channel returns exactly one transaction per request: status
// enqueued, dequeued, empty (dequeue of an empty queue) or full (the enqueue
// was dropped). out_value and out_priority carry the removed entry on a
// dequeue and are zero otherwise.
// Timing: a request is taken in the idle state and executed in the execute
// state, which waits while an earlier response has not been taken. The
// response valid and payload are registered when the operation executes.
// No new request is taken until the operation has executed. Execution is
// a parallel compare of the new priority against all sixteen entries and
// a one-position shift of the sorted store.
// Reset clears the entry count and the response valid; the queue is empty
// afterwards. When the receiver stalls, one further request is still taken
// and held; it executes as soon as the waiting response is taken.
`default_nettype none

module sorted_min_priority_queue (
    input  wire logic  clk,
    input  wire logic  rst_n,
    smpq_req_if.sink   req,
    smpq_rsp_if.source rsp
);

    smpq_pkg::cmd_t cmd;

    smpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd)
    );

    smpq_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .op            (req.op),
        .item_value    (req.item_value),
        .item_priority (req.item_priority),
        .status        (rsp.status),
        .out_value     (rsp.out_value),
        .out_priority  (rsp.out_priority)
    );

endmodule

`default_nettype wire
